>>> sv/tbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

  // Depth of the command queue between front and back.
  localparam int QueueDepthDefault = 4;

  // Operation codes carried by each input item.
  typedef enum logic [3:0] {
    OP_BEGIN     = 4'd0,
    OP_INT       = 4'd1,
    OP_STR_START = 4'd2,
    OP_STR_BYTE  = 4'd3,
    OP_KEY_BYTE  = 4'd4,
    OP_DATA_HDR  = 4'd5,
    OP_DATA_BYTE = 4'd6,
    OP_NULL      = 4'd7,
    OP_ARRAY     = 4'd8,
    OP_DICT      = 4'd9,
    OP_TERM      = 4'd10
  } op_t;

  // Result status codes.
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusNoRoom = 2'd1;
  localparam logic [1:0] StatusBadKey = 2'd2;

  // Tag bytes.
  localparam logic [7:0] TagInt32    = 8'hA6;
  localparam logic [7:0] TagInt64    = 8'hC6;
  localparam logic [7:0] TagString   = 8'h81;
  localparam logic [7:0] TagData1    = 8'h05;
  localparam logic [7:0] TagData2    = 8'h25;
  localparam logic [7:0] TagData3    = 8'h45;
  localparam logic [7:0] TagData4    = 8'h65;
  localparam logic [7:0] TagNull     = 8'h04;
  localparam logic [7:0] TagArray    = 8'h82;
  localparam logic [7:0] TagDict     = 8'h83;
  localparam logic [7:0] TagTerm     = 8'h00;
  localparam logic [7:0] KeyLastMark = 8'h80;

  // One classified operation: a first byte followed by nbytes value bytes,
  // or a single status beat when fail is set.
  typedef struct packed {
    logic        fail;
    logic [1:0]  status;
    logic [7:0]  tag;
    logic [63:0] val;
    logic [3:0]  nbytes;
    logic [31:0] offset;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/tbs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_front
  import tbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_take,
  input  wire logic [3:0]         operation,
  input  wire logic signed [63:0] int_value,
  input  wire logic [7:0]         data_byte,
  input  wire logic [31:0]        payload_length,
  input  wire logic               final_key_char,
  input  wire logic               cfg_write,
  input  wire logic [31:0]        cfg_data,
  output cmd_t                    cmd,
  output logic                    cmd_push
);

  logic [31:0] buffer_capacity;
  logic [31:0] write_offset;
  logic [31:0] write_offset_next;

  logic        has_cmd;
  logic        key_bad;
  logic        room_ok;
  logic [32:0] need;
  logic [7:0]  tag;
  logic [63:0] val;
  logic [3:0]  nbytes;
  logic        int_small;

  assign int_small = (&int_value[63:31]) || !(|int_value[63:31]);

  // Classify the operation: tag, value bytes and room needed.
  always_comb begin
    has_cmd = 1'b1;
    key_bad = 1'b0;
    need    = 33'd1;
    tag     = data_byte;
    val     = '0;
    nbytes  = 4'd0;
    unique case (op_t'(operation))
      OP_BEGIN: begin
        has_cmd = 1'b0;
      end
      OP_INT: begin
        val = int_value;
        if (int_small) begin
          tag    = TagInt32;
          nbytes = 4'd4;
          need   = 33'd5;
        end else begin
          tag    = TagInt64;
          nbytes = 4'd8;
          need   = 33'd9;
        end
      end
      OP_STR_START: begin
        tag  = TagString;
        need = 33'd2;
      end
      OP_STR_BYTE, OP_DATA_BYTE: begin
        tag = data_byte;
      end
      OP_KEY_BYTE: begin
        key_bad = data_byte[7];
        tag     = final_key_char ? (data_byte | KeyLastMark) : data_byte;
      end
      OP_DATA_HDR: begin
        val = {32'd0, payload_length};
        if (payload_length < 32'h100) begin
          tag    = TagData1;
          nbytes = 4'd1;
        end else if (payload_length < 32'h10000) begin
          tag    = TagData2;
          nbytes = 4'd2;
        end else if (payload_length < 32'h1000000) begin
          tag    = TagData3;
          nbytes = 4'd3;
        end else begin
          tag    = TagData4;
          nbytes = 4'd4;
        end
        need = {1'b0, payload_length} + 33'(nbytes) + 33'd1;
      end
      OP_NULL:  tag = TagNull;
      OP_ARRAY: tag = TagArray;
      OP_DICT:  tag = TagDict;
      OP_TERM:  tag = TagTerm;
      default: begin
        has_cmd = 1'b0;
      end
    endcase
  end

  // Room check in wide arithmetic so it cannot wrap.
  assign room_ok = ({2'b00, write_offset} + {1'b0, need}) <= {2'b00, buffer_capacity};

  // Build the command for the back end.
  always_comb begin
    cmd.fail   = !room_ok || key_bad;
    cmd.status = !room_ok ? StatusNoRoom : (key_bad ? StatusBadKey : StatusOk);
    cmd.tag    = tag;
    cmd.val    = val;
    cmd.nbytes = nbytes;
    cmd.offset = write_offset;
  end

  assign cmd_push = in_take && has_cmd;

  // Next write offset.
  always_comb begin
    write_offset_next = write_offset;
    if (in_take) begin
      if (op_t'(operation) == OP_BEGIN) begin
        write_offset_next = '0;
      end else if (has_cmd && room_ok && !key_bad) begin
        write_offset_next = write_offset + 32'(nbytes) + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_offset    <= '0;
      buffer_capacity <= '0;
    end else begin
      write_offset <= write_offset_next;
      if (cfg_write) begin
        buffer_capacity <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/tbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_queue
  import tbs_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en && !empty) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if ((wr_en && !full) && !(rd_en && !empty)) begin
        count <= count + CntW'(1);
      end else if (!(wr_en && !full) && (rd_en && !empty)) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/tbs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_back
  import tbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cmd_t   cmd,
  input  wire logic   cmd_empty,
  output logic        cmd_pop,
  output logic        empty,
  input  wire logic   pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [31:0] byte_offset,
  output logic        last_of_run,
  output logic [1:0]  status
);

  logic        out_full;
  logic        load;
  logic [3:0]  beat_idx;
  logic [2:0]  sel;
  logic [7:0]  beat_byte;
  logic        beat_last;

  assign load    = !cmd_empty && (!out_full || pop);
  assign sel     = 3'(beat_idx - 4'd1);
  assign beat_last = cmd.fail || (beat_idx == cmd.nbytes);
  assign cmd_pop = load && beat_last;
  assign empty   = !out_full;

  // Pick the byte for this beat: tag first, then value bytes little endian.
  always_comb begin
    if (beat_idx == 4'd0) begin
      beat_byte = cmd.tag;
    end else begin
      beat_byte = cmd.val[{sel, 3'b000} +: 8];
    end
  end

  // Beat counter within the head command.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx <= '0;
      out_full <= 1'b0;
    end else begin
      if (load) begin
        beat_idx <= beat_last ? 4'd0 : beat_idx + 4'd1;
      end
      if (load) begin
        out_full <= 1'b1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= cmd.fail ? 8'd0 : beat_byte;
      byte_valid  <= !cmd.fail;
      byte_offset <= cmd.offset + 32'(beat_idx);
      last_of_run <= beat_last;
      status      <= cmd.status;
    end
  end

endmodule

`default_nettype wire

>>> sv/tagged_binary_serializer.sv
// An item is written into the command queue, and its first result is then loaded into the output register.
// One result per cycle while the receiver keeps popping; an item that makes n results holds
// the output stage until its last result is loaded, so single-byte items stream at one per cycle.
// A four-entry command queue sets how far the input may run ahead of the output.
// Reset clears the write offset, the buffer capacity, the queue and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module tagged_binary_serializer
  import tbs_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [3:0]         operation,
  input  wire logic signed [63:0] int_value,
  input  wire logic [7:0]         data_byte,
  input  wire logic [31:0]        payload_length,
  input  wire logic               final_key_char,
  output logic                    empty,
  input  wire logic               pop,
  output logic [7:0]              out_byte,
  output logic                    byte_valid,
  output logic [31:0]             byte_offset,
  output logic                    last_of_run,
  output logic [1:0]              status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic front_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign full      = q_full;
  assign cfg_ready = 1'b1;

  // Front: takes items, checks room and tracks the write offset.
  tbs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_take        (push && !q_full),
    .operation      (operation),
    .int_value      (int_value),
    .data_byte      (data_byte),
    .payload_length (payload_length),
    .final_key_char (final_key_char),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .cmd            (front_cmd),
    .cmd_push       (front_push)
  );

  // Command queue between front and back.
  tbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (head_cmd),
    .empty   (q_empty)
  );

  // Back: expands each command into byte beats.
  tbs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head_cmd),
    .cmd_empty   (q_empty),
    .cmd_pop     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .byte_offset (byte_offset),
    .last_of_run (last_of_run),
    .status      (status)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_tagged_binary_serializer.sv
`timescale 1ns / 1ps

module tb_tagged_binary_serializer;
  import tbs_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles = 8;
  localparam int MaxReported = 10;
  localparam logic [3:0] OpUnused = 4'd15;

  // One input item as the sender presents it.
  typedef struct packed {
    logic [3:0]         op;
    logic signed [63:0] ival;
    logic [7:0]         db;
    logic [31:0]        plen;
    logic               fin;
  } ser_item_t;

  // One result beat as the receiver sees it.
  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic [31:0] offset;
    logic        last;
    logic [1:0]  status;
  } ser_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [3:0]         operation = '0;
  logic signed [63:0] int_value = '0;
  logic [7:0]         data_byte = '0;
  logic [31:0]        payload_length = '0;
  logic               final_key_char = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         out_byte;
  logic               byte_valid;
  logic [31:0]        byte_offset;
  logic               last_of_run;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = '0;

  // Items waiting to be sent, and the beats the encoder is expected to produce.
  ser_item_t pending_items[$];
  ser_beat_t expected_beats[$];

  // Shadow copy of the encoder state.
  logic [31:0] model_offset = '0;
  logic [31:0] model_capacity = '0;

  int  mismatch_count = 0;
  int  queued_total = 0;
  int  send_odds = 0;
  int  recv_odds = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  always #5 clk = ~clk;

  tagged_binary_serializer uut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .int_value      (int_value),
    .data_byte      (data_byte),
    .payload_length (payload_length),
    .final_key_char (final_key_char),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .byte_offset    (byte_offset),
    .last_of_run    (last_of_run),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Room checks are done in 64 bits so that they never wrap.
  function automatic bit room_for(logic [63:0] need);
    return ({32'd0, model_offset} + need) <= {32'd0, model_capacity};
  endfunction

  // A refused operation gives a single status beat and leaves the offset alone.
  task automatic expect_refusal(logic [1:0] code);
    expected_beats.push_back('{8'h00, 1'b0, model_offset, 1'b1, code});
  endtask

  // A tag byte followed by count little-endian bytes of the value.
  task automatic expect_tagged(logic [7:0] tag, logic [63:0] value, int count);
    logic [7:0] b;
    for (int k = 0; k <= count; k++) begin
      b = (k == 0) ? tag : value[8 * (k - 1) +: 8];
      expected_beats.push_back('{b, 1'b1, model_offset + k, k == count, StatusOk});
    end
    model_offset += count + 1;
  endtask

  task automatic expect_single(logic [7:0] b);
    if (!room_for(64'd1)) begin
      expect_refusal(StatusNoRoom);
    end else begin
      expect_tagged(b, 64'd0, 0);
    end
  endtask

  // Works out the beats that one accepted item must produce.
  task automatic encode_item(ser_item_t it);
    logic [63:0] len;
    len = {32'd0, it.plen};
    case (it.op)
      OP_BEGIN: begin
        model_offset = '0;
      end
      OP_INT: begin
        // The value fits in 32 signed bits when bits 63..31 are all equal.
        if (&it.ival[63:31] || ~|it.ival[63:31]) begin
          if (!room_for(64'd5)) expect_refusal(StatusNoRoom);
          else expect_tagged(TagInt32, it.ival, 4);
        end else begin
          if (!room_for(64'd9)) expect_refusal(StatusNoRoom);
          else expect_tagged(TagInt64, it.ival, 8);
        end
      end
      OP_STR_START: begin
        // A string needs room for its tag and at least one more byte.
        if ({32'd0, model_offset} + 64'd1 >= {32'd0, model_capacity}) begin
          expect_refusal(StatusNoRoom);
        end else begin
          expect_tagged(TagString, 64'd0, 0);
        end
      end
      OP_STR_BYTE, OP_DATA_BYTE: begin
        expect_single(it.db);
      end
      OP_KEY_BYTE: begin
        // Lack of room wins over a bad key byte.
        if (!room_for(64'd1)) begin
          expect_refusal(StatusNoRoom);
        end else if (it.db[7]) begin
          expect_refusal(StatusBadKey);
        end else begin
          expect_single(it.fin ? (it.db | KeyLastMark) : it.db);
        end
      end
      OP_DATA_HDR: begin
        // The header reserves room for itself and the whole payload.
        if (it.plen < 32'h100) begin
          if (!room_for(len + 64'd2)) expect_refusal(StatusNoRoom);
          else expect_tagged(TagData1, len, 1);
        end else if (it.plen < 32'h10000) begin
          if (!room_for(len + 64'd3)) expect_refusal(StatusNoRoom);
          else expect_tagged(TagData2, len, 2);
        end else if (it.plen < 32'h1000000) begin
          if (!room_for(len + 64'd4)) expect_refusal(StatusNoRoom);
          else expect_tagged(TagData3, len, 3);
        end else begin
          if (!room_for(len + 64'd5)) expect_refusal(StatusNoRoom);
          else expect_tagged(TagData4, len, 4);
        end
      end
      OP_NULL:  expect_single(TagNull);
      OP_ARRAY: expect_single(TagArray);
      OP_DICT:  expect_single(TagDict);
      OP_TERM:  expect_single(TagTerm);
      default: begin
        // Unused codes are dropped without a trace.
      end
    endcase
  endtask

  task automatic add_item(logic [3:0] op, logic signed [63:0] ival, logic [7:0] db,
                          logic [31:0] plen, logic fin);
    pending_items.push_back('{op, ival, db, plen, fin});
    queued_total++;
  endtask

  // Integers spread over small values, both widths and the 32-bit boundary.
  function automatic logic signed [63:0] random_int();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(4, 0))
      0: return {{56{w[7]}}, w[7:0]};
      1: return {{32{w[31]}}, w};
      2: return {$urandom, w};
      3: begin
        case (w[1:0])
          2'd0:    return 64'h0000_0000_7FFF_FFFF;
          2'd1:    return 64'h0000_0000_8000_0000;
          2'd2:    return 64'hFFFF_FFFF_8000_0000;
          default: return 64'hFFFF_FFFF_7FFF_FFFF;
        endcase
      end
      default: return {{32{~w[31]}}, w};
    endcase
  endfunction

  // A well-formed key: one or more 7-bit bytes, the last one marked.
  task automatic add_key();
    int n;
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      add_item(OP_KEY_BYTE, random_int(), $urandom_range(127, 0), $urandom, i == n - 1);
    end
  endtask

  // A well-formed scalar: integer, string, data block or null.
  task automatic add_scalar();
    int n;
    logic [31:0] len;
    case ($urandom_range(3, 0))
      0: add_item(OP_INT, random_int(), $urandom, $urandom, $urandom);
      1: begin
        add_item(OP_STR_START, random_int(), $urandom, $urandom, $urandom);
        repeat ($urandom_range(5, 0)) begin
          add_item(OP_STR_BYTE, 64'sd0, $urandom_range(255, 1), $urandom, $urandom);
        end
        add_item(OP_STR_BYTE, 64'sd0, 8'h00, $urandom, $urandom);
      end
      2: begin
        // Mostly short payloads sent whole; sometimes a length class edge.
        if ($urandom_range(4, 0) != 0) begin
          n = $urandom_range(6, 0);
          len = n;
        end else begin
          n = 2;
          case ($urandom_range(6, 0))
            0:       len = 32'hFF;
            1:       len = 32'h100;
            2:       len = 32'hFFFF;
            3:       len = 32'h10000;
            4:       len = 32'hFF_FFFF;
            5:       len = 32'h100_0000;
            default: len = $urandom;
          endcase
        end
        add_item(OP_DATA_HDR, random_int(), $urandom, len, $urandom);
        repeat (n) add_item(OP_DATA_BYTE, 64'sd0, $urandom, $urandom, $urandom);
      end
      default: add_item(OP_NULL, random_int(), $urandom, $urandom, $urandom);
    endcase
  endtask

  // Mostly well-formed documents, with some noise and broken fragments.
  task automatic queue_random(int count);
    int start;
    int pick;
    start = queued_total;
    while (queued_total - start < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        add_item($urandom_range(15, 0), {$urandom, $urandom}, $urandom, $urandom, $urandom);
      end else if (pick < 20) begin
        add_item(OP_BEGIN, random_int(), $urandom, $urandom, $urandom);
      end else if (pick < 30) begin
        add_item(OP_DICT, 64'sd0, $urandom, $urandom, $urandom);
        repeat ($urandom_range(2, 1)) begin
          add_key();
          add_scalar();
        end
        add_item(OP_TERM, 64'sd0, $urandom, $urandom, $urandom);
      end else if (pick < 38) begin
        add_item(OP_ARRAY, 64'sd0, $urandom, $urandom, $urandom);
        repeat ($urandom_range(3, 0)) add_scalar();
        add_item(OP_TERM, 64'sd0, $urandom, $urandom, $urandom);
      end else if (pick < 43) begin
        add_item(OP_KEY_BYTE, 64'sd0, $urandom, $urandom, $urandom);
      end else begin
        add_scalar();
      end
    end
  endtask

  // Waits until every item is sent and every beat has come, then lets the
  // pipeline settle in case the last items produced nothing.
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || expected_beats.size() != 0 || push);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_capacity = value;
  endtask

  task automatic run_random(logic [31:0] capacity, int s_odds, int r_odds, int count);
    drain();
    write_capacity(capacity);
    send_odds = s_odds;
    recv_odds = r_odds;
    @(negedge clk);
    queue_random(count);
  endtask

  // Driver: presents queued items and idles in random bursts.
  always @(posedge clk) begin : driver_blk
    ser_item_t next_item;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_item(pending_items.pop_front());
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (!calm && send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0) begin
        send_gap = $urandom_range(12, 0);
        push <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items[0];
        push <= 1'b1;
        operation <= next_item.op;
        int_value <= next_item.ival;
        data_byte <= next_item.db;
        payload_length <= next_item.plen;
        final_key_char <= next_item.fin;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: takes result beats, stalls in random bursts, and checks each
  // beat against the oldest expectation.
  always @(posedge clk) begin : monitor_blk
    ser_beat_t seen;
    ser_beat_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen = '{out_byte, byte_valid, byte_offset, last_of_run, status};
        if (expected_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("unexpected beat: byte=%02h valid=%0b offset=%0d last=%0b status=%0d",
                     seen.data, seen.valid, seen.offset, seen.last, seen.status);
          end
        end else begin
          want = expected_beats.pop_front();
          if (seen.data !== want.data || seen.valid !== want.valid ||
              seen.offset !== want.offset || seen.last !== want.last ||
              seen.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported) begin
              $display("beat mismatch: want byte=%02h valid=%0b offset=%0d last=%0b status=%0d",
                       want.data, want.valid, want.offset, want.last, want.status);
              $display("                got byte=%02h valid=%0b offset=%0d last=%0b status=%0d",
                       seen.data, seen.valid, seen.offset, seen.last, seen.status);
            end
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!calm && recv_odds != 0 && $urandom_range(recv_odds - 1, 0) == 0) begin
        recv_gap = $urandom_range(12, 0);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_tagged_binary_serializer failed");
        $finish;
      end
    end
  end

  // Stimulus sequence: directed checks, then random phases at several capacities.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_odds = 4;
    recv_odds = 4;

    // Capacity still holds its reset value of zero, so nothing has room;
    // the bad key byte must report no room rather than a bad key.
    @(negedge clk);
    add_item(OP_NULL, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_KEY_BYTE, 64'sd0, 8'h80, 32'd0, 1'b1);
    drain();

    // Every operation with field extremes in a 64-byte buffer.
    write_capacity(32'd64);
    @(negedge clk);
    add_item(OP_BEGIN, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_INT, -64'sd1, 8'h00, 32'd0, 1'b0);
    add_item(OP_INT, 64'h0000_0000_7FFF_FFFF, 8'h00, 32'd0, 1'b0);
    add_item(OP_INT, 64'hFFFF_FFFF_8000_0000, 8'h00, 32'd0, 1'b0);
    add_item(OP_INT, 64'h0000_0000_8000_0000, 8'h00, 32'd0, 1'b0);
    add_item(OP_INT, 64'h8000_0000_0000_0000, 8'h00, 32'd0, 1'b0);
    add_item(OP_INT, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    add_item(OP_STR_START, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_STR_BYTE, 64'sd0, 8'h41, 32'd0, 1'b0);
    add_item(OP_STR_BYTE, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_KEY_BYTE, 64'sd0, 8'h80, 32'd0, 1'b0);
    add_item(OP_KEY_BYTE, 64'sd0, 8'h6B, 32'd0, 1'b0);
    add_item(OP_KEY_BYTE, 64'sd0, 8'h7F, 32'd0, 1'b1);
    add_item(OP_DICT, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_ARRAY, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_NULL, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_TERM, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_DATA_HDR, 64'sd0, 8'h00, 32'd5, 1'b0);
    add_item(OP_DATA_BYTE, 64'sd0, 8'hFF, 32'd0, 1'b0);
    add_item(OpUnused, 64'sd0, 8'h00, 32'd0, 1'b0);
    add_item(OP_DATA_HDR, 64'sd0, 8'h00, 32'd256, 1'b0);
    drain();

    // Largest capacity: the wide length classes and a payload that cannot fit.
    write_capacity(32'hFFFF_FFFF);
    @(negedge clk);
    add_item(OP_DATA_HDR, 64'sd0, 8'h00, 32'h1_0000, 1'b0);
    add_item(OP_DATA_HDR, 64'sd0, 8'h00, 32'h100_0000, 1'b0);
    add_item(OP_DATA_HDR, 64'sd0, 8'h00, 32'hFFFF_FFFF, 1'b0);

    // The small capacity phase starts with the offset already past it.
    run_random($urandom_range(40, 8), 6, 0, 30);
    run_random(32'd300, 3, 5, 35);
    run_random(32'd0, 8, 3, 8);
    run_random(32'hFFFF_FFFF, 0, 4, 30);
    drain();
    calm = 1'b1;
    run_random(32'd4096, 0, 0, 22);

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("tb_tagged_binary_serializer passed");
    end else begin
      $display("tb_tagged_binary_serializer failed");
    end
    $finish;
  end

endmodule
